// File: rtl/ghm_pkg.sv
package ghm_pkg;

    localparam int NUM_BINS = 64;
    localparam int BIN_W    = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int NB_W     = $clog2(NUM_BINS + 1);
    localparam int STEP_W   = $clog2(BIN_W + 1);

    // shared multiplier operand and product widths
    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;

    // truth value, its offset from the first bin edge, square accumulator
    localparam int VAL_W  = 42;
    localparam int DIFF_W = VAL_W + 1;
    localparam int SQ_W   = 80;

    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DETECT_LOW  = 3'd0,
        REG_DETECT_HIGH = 3'd1,
        REG_TRUTH_SCALE = 3'd2,
        REG_TRUTH_BIAS  = 3'd3,
        REG_HIST_LOW    = 3'd4,
        REG_HIST_WIDTH  = 3'd5,
        REG_HIST_BINS   = 3'd6
    } cfg_reg_t;

    typedef enum logic {
        OP_ACCUM = 1'b0,
        OP_READ  = 1'b1
    } op_t;

    typedef struct packed {
        logic       op;
        logic [7:0] truth_code;
        logic [7:0] detect_code;
        logic [5:0] bin_select;
    } in_item_t;

    typedef struct packed {
        logic               counted;
        logic [5:0]         bin_index;
        logic [31:0]        bin_count;
        logic [31:0]        total_count;
        logic signed [63:0] value_sum;
        logic [63:0]        value_sum_sq;
    } out_item_t;

endpackage

// File: rtl/gated_histogram_moments.sv
// binned sample: truth-value multiply, offset and range check, then a restoring divider
// stepping one quotient bit a cycle and three squaring passes on one multiplier before the commit
// read: a bin store read; gated-out: straight to the result; outside the bins in use: range check
// one item in flight: the next input transfer comes in the cycle after the result is loaded,
// later while a stalled result holds the output register
// reset sets the configuration to its defaults and clears the totals and the per-bin valid bits
module gated_histogram_moments
    import ghm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_item_t            out_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_RD     = 14'b00000000000010,
        S_RDW    = 14'b00000000000100,
        S_MULV   = 14'b00000000001000,
        S_VAL    = 14'b00000000010000,
        S_DIFF   = 14'b00000000100000,
        S_RANGE  = 14'b00000001000000,
        S_DIV    = 14'b00000010000000,
        S_SQ0    = 14'b00000100000000,
        S_SQ1    = 14'b00001000000000,
        S_SQ2    = 14'b00010000000000,
        S_SQ3    = 14'b00100000000000,
        S_COMMIT = 14'b01000000000000,
        S_RESULT = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [7:0]  det_low_reg, det_high_reg;
    logic [31:0] scale_reg, bias_reg, hlow_reg;
    logic [30:0] hwidth_reg;
    logic [6:0]  hbins_reg;

    // accumulated state
    logic [31:0]        total_reg, total_next;
    logic signed [63:0] sum_reg, sum_next;
    logic [63:0]        sumsq_reg, sumsq_next;
    logic [NUM_BINS-1:0] vld_reg, vld_next;

    // item and working registers
    in_item_t           item_reg, item_next;
    logic [VAL_W-1:0]   v_reg, v_next;
    logic [DIFF_W-1:0]  diff_reg, diff_next;
    logic [VAL_W-1:0]   mag_reg, mag_next;
    logic               sat_reg, sat_next;
    logic [DIFF_W-1:0]  rem_reg, rem_next;
    logic [DIFF_W-1:0]  div_reg, div_next;
    logic [BIN_W-1:0]   q_reg, q_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [SQ_W-1:0]    acc_reg, acc_next;
    logic [31:0]        cnt_reg, cnt_next;
    logic               rd_vld_reg;

    // result staging and output
    logic               res_counted_reg, res_counted_next;
    logic [5:0]         res_idx_reg, res_idx_next;
    logic [31:0]        res_count_reg, res_count_next;
    logic               out_valid_reg;
    out_item_t          out_reg;
    logic               out_load;

    // shared multiplier
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;

    // bin store
    logic              ram_we;
    logic [BIN_W-1:0]  ram_raddr;
    logic [31:0]       ram_rdata;
    logic [31:0]       cnt_inc;

    logic              in_xfer;
    logic              gate_ok;
    logic [NB_W-1:0]   nbins;
    logic [DIFF_W:0]   trial;
    logic [64:0]       sum_wide;
    logic [64:0]       sumsq_wide;
    logic [63:0]       sq_val;
    logic              sel_ok;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign gate_ok = (in_data.detect_code >= det_low_reg) &&
                     (in_data.detect_code <= det_high_reg) && (hwidth_reg != '0);
    assign nbins   = (32'(hbins_reg) < NUM_BINS) ? NB_W'(hbins_reg) : NB_W'(NUM_BINS);
    assign trial   = {1'b0, rem_reg} - {1'b0, div_reg};
    assign sel_ok  = (32'(item_reg.bin_select) < NUM_BINS);
    assign cnt_inc = (cnt_reg == '1) ? cnt_reg : cnt_reg + 32'd1;
    assign sq_val  = sat_reg ? '1 : acc_reg[SQ_W-1:16];

    assign sum_wide   = {sum_reg[63], sum_reg} + {{(65 - VAL_W){v_reg[VAL_W-1]}}, v_reg};
    assign sumsq_wide = {1'b0, sumsq_reg} + {1'b0, sq_val};

    assign ram_raddr = (state_reg == S_RD) ? BIN_W'(item_reg.bin_select) : q_reg;
    assign ram_we    = (state_reg == S_COMMIT);
    assign out_load  = (state_reg == S_RESULT) && (!out_valid_reg || !out_stall);

    ghm_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    ghm_ram #(
        .WIDTH (32),
        .DEPTH (NUM_BINS)
    ) u_bins (
        .clk   (clk),
        .we    (ram_we),
        .waddr (q_reg),
        .wdata (cnt_inc),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_MULV:
            begin
                mul_a = {25'd0, item_reg.truth_code};
                mul_b = {scale_reg[31], scale_reg};
            end
            S_DIFF:
            begin
                mul_a = MUL_W'(nbins);
                mul_b = {2'b00, hwidth_reg};
            end
            S_SQ0:
            begin
                mul_a = {13'd0, mag_reg[39:20]};
                mul_b = {13'd0, mag_reg[39:20]};
            end
            S_SQ1:
            begin
                mul_a = {13'd0, mag_reg[39:20]};
                mul_b = {13'd0, mag_reg[19:0]};
            end
            S_SQ2:
            begin
                mul_a = {13'd0, mag_reg[19:0]};
                mul_b = {13'd0, mag_reg[19:0]};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // sequencer and datapath
    always_comb
    begin
        state_next       = state_reg;
        item_next        = item_reg;
        v_next           = v_reg;
        diff_next        = diff_reg;
        mag_next         = mag_reg;
        sat_next         = sat_reg;
        rem_next         = rem_reg;
        div_next         = div_reg;
        q_next           = q_reg;
        step_next        = step_reg;
        acc_next         = acc_reg;
        cnt_next         = cnt_reg;
        total_next       = total_reg;
        sum_next         = sum_reg;
        sumsq_next       = sumsq_reg;
        vld_next         = vld_reg;
        res_counted_next = res_counted_reg;
        res_idx_next     = res_idx_reg;
        res_count_next   = res_count_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    item_next        = in_data;
                    res_counted_next = 1'b0;
                    res_idx_next     = '0;
                    res_count_next   = '0;
                    if (in_data.op == OP_READ)
                    begin
                        state_next = S_RD;
                    end
                    else if (gate_ok)
                    begin
                        state_next = S_MULV;
                    end
                    else
                    begin
                        state_next = S_RESULT;
                    end
                end
            end
            S_RD:
            begin
                state_next = S_RDW;
            end
            S_RDW:
            begin
                res_idx_next   = item_reg.bin_select;
                res_count_next = (sel_ok && rd_vld_reg) ? ram_rdata : '0;
                state_next     = S_RESULT;
            end
            S_MULV:
            begin
                state_next = S_VAL;
            end
            S_VAL:
            begin
                v_next     = {prod[40], prod[40:0]} + {{(VAL_W - 32){bias_reg[31]}}, bias_reg};
                state_next = S_DIFF;
            end
            S_DIFF:
            begin
                diff_next  = {v_reg[VAL_W-1], v_reg} - {{(DIFF_W - 32){hlow_reg[31]}}, hlow_reg};
                mag_next   = v_reg[VAL_W-1] ? (VAL_W'(0) - v_reg) : v_reg;
                state_next = S_RANGE;
            end
            S_RANGE:
            begin
                sat_next = (mag_reg[VAL_W-1:40] != '0);
                // prod holds the end of the last bin in use
                if (diff_reg[DIFF_W-1] || (diff_reg >= {5'd0, prod[37:0]}))
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    rem_next   = diff_reg;
                    div_next   = DIFF_W'({hwidth_reg, {(BIN_W - 1){1'b0}}});
                    q_next     = '0;
                    step_next  = STEP_W'(BIN_W - 1);
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (!trial[DIFF_W])
                begin
                    rem_next = trial[DIFF_W-1:0];
                end
                q_next    = {q_reg[BIN_W-2:0], !trial[DIFF_W]};
                div_next  = div_reg >> 1;
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    state_next = S_SQ0;
                end
            end
            S_SQ0:
            begin
                state_next = S_SQ1;
            end
            S_SQ1:
            begin
                acc_next   = SQ_W'({prod[39:0], 40'd0});
                cnt_next   = rd_vld_reg ? ram_rdata : '0;
                state_next = S_SQ2;
            end
            S_SQ2:
            begin
                acc_next   = acc_reg + SQ_W'({prod[39:0], 21'd0});
                state_next = S_SQ3;
            end
            S_SQ3:
            begin
                acc_next   = acc_reg + SQ_W'(prod[39:0]);
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                vld_next[q_reg] = 1'b1;
                total_next = (total_reg == '1) ? total_reg : total_reg + 32'd1;
                if (sum_wide[64] != sum_wide[63])
                begin
                    sum_next = sum_wide[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
                end
                else
                begin
                    sum_next = sum_wide[63:0];
                end
                sumsq_next       = sumsq_wide[64] ? '1 : sumsq_wide[63:0];
                res_counted_next = 1'b1;
                res_idx_next     = 6'(q_reg);
                res_count_next   = cnt_inc;
                state_next       = S_RESULT;
            end
            S_RESULT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            total_reg     <= '0;
            sum_reg       <= '0;
            sumsq_reg     <= '0;
            vld_reg       <= '0;
            det_low_reg   <= 8'd0;
            det_high_reg  <= 8'd255;
            scale_reg     <= 32'd65536;
            bias_reg      <= '0;
            hlow_reg      <= '0;
            hwidth_reg    <= 31'd65536;
            hbins_reg     <= 7'd64;
        end
        else
        begin
            state_reg <= state_next;
            total_reg <= total_next;
            sum_reg   <= sum_next;
            sumsq_reg <= sumsq_next;
            vld_reg   <= vld_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_DETECT_LOW:  det_low_reg  <= cfg_data[7:0];
                    REG_DETECT_HIGH: det_high_reg <= cfg_data[7:0];
                    REG_TRUTH_SCALE: scale_reg    <= cfg_data;
                    REG_TRUTH_BIAS:  bias_reg     <= cfg_data;
                    REG_HIST_LOW:    hlow_reg     <= cfg_data;
                    REG_HIST_WIDTH:  hwidth_reg   <= cfg_data[30:0];
                    REG_HIST_BINS:   hbins_reg    <= cfg_data[6:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg        <= item_next;
        v_reg           <= v_next;
        diff_reg        <= diff_next;
        mag_reg         <= mag_next;
        sat_reg         <= sat_next;
        rem_reg         <= rem_next;
        div_reg         <= div_next;
        q_reg           <= q_next;
        step_reg        <= step_next;
        acc_reg         <= acc_next;
        cnt_reg         <= cnt_next;
        res_counted_reg <= res_counted_next;
        res_idx_reg     <= res_idx_next;
        res_count_reg   <= res_count_next;
        // valid bit follows the registered read data
        rd_vld_reg      <= vld_reg[ram_raddr];
        if (out_load)
        begin
            out_reg.counted      <= res_counted_reg;
            out_reg.bin_index    <= res_idx_reg;
            out_reg.bin_count    <= res_count_reg;
            out_reg.total_count  <= total_reg;
            out_reg.value_sum    <= sum_reg;
            out_reg.value_sum_sq <= sumsq_reg;
        end
    end

endmodule

// File: rtl/ghm_ram.sv
module ghm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/ghm_mul.sv
module ghm_mul
    import ghm_pkg::*;
(
    input  logic                     clk,
    input  logic signed [MUL_W-1:0]  a,
    input  logic signed [MUL_W-1:0]  b,
    output logic signed [PROD_W-1:0] p
);

    always_ff @(posedge clk)
    begin
        p <= a * b;
    end

endmodule
